FILE: design/bmt_pkg.sv
// shared types, constants and the command byte decoder for the bracket tokenizer
package bmt_pkg;

  localparam int MAX_TOKENS_DEF  = 65536;
  localparam int MAX_NESTING_DEF = 256;
  localparam int POS_W           = 16;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_OPEN  = 8'd91;
  localparam logic [7:0] CH_CLOSE = 8'd93;

  localparam logic ITEM_BYTE = 1'b0;
  localparam logic ITEM_END  = 1'b1;

  typedef enum logic [3:0] {
    TK_PLUS  = 4'd0,
    TK_MINUS = 4'd1,
    TK_COMMA = 4'd2,
    TK_DOT   = 4'd3,
    TK_LT    = 4'd4,
    TK_GT    = 4'd5,
    TK_OPEN  = 4'd6,
    TK_CLOSE = 4'd7,
    TK_END   = 4'd8
  } tok_kind_t;

  typedef enum logic [2:0] {
    ST_OK              = 3'd0,
    ST_UNMATCHED_CLOSE = 3'd1,
    ST_UNMATCHED_OPEN  = 3'd2,
    ST_TOO_DEEP        = 3'd3,
    ST_TOO_LONG        = 3'd4
  } status_t;

  typedef struct packed {
    logic      cmd;
    tok_kind_t kind;
  } decode_t;

  function automatic decode_t classify(input logic [7:0] code);
    decode_t d;
    d.cmd  = 1'b1;
    d.kind = TK_PLUS;
    case (code)
      CH_PLUS:  d.kind = TK_PLUS;
      CH_MINUS: d.kind = TK_MINUS;
      CH_COMMA: d.kind = TK_COMMA;
      CH_DOT:   d.kind = TK_DOT;
      CH_LT:    d.kind = TK_LT;
      CH_GT:    d.kind = TK_GT;
      CH_OPEN:  d.kind = TK_OPEN;
      CH_CLOSE: d.kind = TK_CLOSE;
      default:  d.cmd  = 1'b0;
    endcase
    return d;
  endfunction

endpackage

FILE: design/bmt_if.sv
// valid/ready channel interfaces for program bytes and tokens
interface bmt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface bmt_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_code;
  logic [15:0] position;
  logic [15:0] jump_position;
  logic [2:0]  status;

  modport source (output valid, output token_code, output position, output jump_position,
                  output status, input ready);
  modport sink   (input valid, input token_code, input position, input jump_position,
                  input status, output ready);
endinterface

FILE: design/bmt_stack.sv
// open bracket stack memory, one write port and one registered read port
module bmt_stack #(
  parameter int DEPTH = bmt_pkg::MAX_NESTING_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [bmt_pkg::POS_W-1:0]     wr_data,
  input  logic                          rd_en,
  input  logic [AW-1:0]                 rd_addr,
  output logic [bmt_pkg::POS_W-1:0]     rd_data
);
  import bmt_pkg::*;

  logic [POS_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next pop so a stalled token keeps its target
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/bracket_matching_tokenizer_unit.sv
// Bracket matching tokenizer: takes one program byte per cycle while the token register is free
// or being taken and, for each of the eight command characters, returns one token in the next
// cycle with its kind, its index among kept tokens and, for a close bracket, the index of the
// matching open bracket; other bytes are absorbed with no token. An end transaction returns the
// token count and the sticky status, then clears the block for the next program. Open bracket
// indexes live in a single-port-write, registered-read stack memory of MAX_NESTING entries: a
// push writes at the current depth and a pop reads at depth minus one in the cycle the byte is
// taken, so the stack never holds a byte back. The token register is the output stage; it is
// refilled in the cycle it is taken.
module bracket_matching_tokenizer_unit #(
  parameter int MAX_TOKENS  = bmt_pkg::MAX_TOKENS_DEF,
  parameter int MAX_NESTING = bmt_pkg::MAX_NESTING_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bmt_in_if.sink     prog,
  bmt_out_if.source  tok
);
  import bmt_pkg::*;

  localparam int CW = $clog2(MAX_TOKENS + 1);
  localparam int DW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic [CW-1:0] cnt, cnt_next;
  logic [DW-1:0] depth, depth_next;
  status_t       err, err_next;

  logic             s1_valid;
  tok_kind_t        s1_kind;
  logic [POS_W-1:0] s1_pos;
  logic             s1_pop;
  status_t          s1_status;

  logic             accept;
  decode_t          dec;
  logic [CW+POS_W-1:0] cnt_wide;
  logic [POS_W-1:0] pos_sat;
  logic             len_full, stack_full, stack_empty;
  logic             push, pop, has_res;
  tok_kind_t        res_kind;
  logic [POS_W-1:0] res_pos;
  status_t          res_status;
  logic [DW-1:0]    depth_m1;
  logic [POS_W-1:0] rd_data;

  assign prog.ready = !rst && (!s1_valid || tok.ready);
  assign accept     = prog.valid && prog.ready;
  assign dec        = classify(prog.char_code);

  assign cnt_wide    = {{POS_W{1'b0}}, cnt};
  assign pos_sat     = (cnt_wide > (CW+POS_W)'(POS_MAX)) ? POS_MAX : cnt_wide[POS_W-1:0];
  assign len_full    = (cnt == CW'(MAX_TOKENS));
  assign stack_full  = (depth == DW'(MAX_NESTING));
  assign stack_empty = (depth == '0);
  assign depth_m1    = depth - DW'(1);

  always_comb begin
    cnt_next   = cnt;
    depth_next = depth;
    err_next   = err;
    push       = 1'b0;
    pop        = 1'b0;
    has_res    = 1'b0;
    res_kind   = dec.kind;
    res_pos    = pos_sat;
    res_status = err;
    if (prog.kind == ITEM_END) begin
      has_res    = 1'b1;
      res_kind   = TK_END;
      if (!stack_empty && err == ST_OK) begin
        res_status = ST_UNMATCHED_OPEN;
      end
      cnt_next   = '0;
      depth_next = '0;
      err_next   = ST_OK;
    end else if (dec.cmd) begin
      has_res = 1'b1;
      if (len_full) begin
        if (err == ST_OK) begin
          err_next = ST_TOO_LONG;
        end
      end else begin
        case (dec.kind)
          TK_OPEN: begin
            if (stack_full) begin
              if (err == ST_OK) begin
                err_next = ST_TOO_DEEP;
              end
            end else begin
              push       = 1'b1;
              depth_next = depth + DW'(1);
            end
          end
          TK_CLOSE: begin
            if (stack_empty) begin
              if (err == ST_OK) begin
                err_next = ST_UNMATCHED_CLOSE;
              end
            end else begin
              pop        = 1'b1;
              depth_next = depth_m1;
            end
          end
          default: ;
        endcase
        cnt_next = cnt + CW'(1);
      end
      res_status = err_next;
    end
  end

  bmt_stack #(
    .DEPTH (MAX_NESTING),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (accept && push),
    .wr_addr (depth[AW-1:0]),
    .wr_data (pos_sat),
    .rd_en   (accept && pop),
    .rd_addr (depth_m1[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      depth    <= '0;
      err      <= ST_OK;
      s1_valid <= 1'b0;
    end else if (accept) begin
      cnt      <= cnt_next;
      depth    <= depth_next;
      err      <= err_next;
      s1_valid <= has_res;
    end else if (tok.ready) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && has_res) begin
      s1_kind   <= res_kind;
      s1_pos    <= res_pos;
      s1_pop    <= pop;
      s1_status <= res_status;
    end
  end

  assign tok.valid         = s1_valid;
  assign tok.token_code    = s1_kind;
  assign tok.position      = s1_pos;
  assign tok.jump_position = s1_pop ? rd_data : '0;
  assign tok.status        = s1_status;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_NESTING))
    else $error("stack depth beyond nesting limit");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_TOKENS))
    else $error("token count beyond length limit");

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (err != ST_OK && !(accept && prog.kind == ITEM_END)) |=> err == $past(err))
    else $error("sticky status changed before end of program");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && prog.kind == ITEM_END) |=> (cnt == '0 && depth == '0 && err == ST_OK))
    else $error("end transaction did not clear state");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (accept && pop) |-> !stack_empty)
    else $error("pop from empty stack");

endmodule

FILE: tb/tb_bracket_matching_tokenizer_unit.sv
// testbench for the bracket matching tokenizer: directed and random programs against a token predictor
`timescale 1ns / 100ps

module tb_bracket_matching_tokenizer_unit;
  import bmt_pkg::*;

  localparam int MAX_TOK      = MAX_TOKENS_DEF;
  localparam int MAX_NEST     = MAX_NESTING_DEF;
  localparam int TOTAL_ITEMS  = 1650;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int TAIL_CYCLES  = 10;

  typedef struct {
    logic [3:0]  kind;
    logic [15:0] pos;
    logic [15:0] jump;
    logic [2:0]  status;
  } token_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_MOSTLY
  } rx_mode_t;

  class token_scoreboard;
    int unsigned n_tokens;
    logic [15:0] open_pos [MAX_NEST];
    int unsigned depth;
    status_t     sticky;
    token_t      want_q [$];
    int unsigned errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      n_tokens = 0;
      depth    = 0;
      sticky   = ST_OK;
    endfunction

    function void raise(status_t s);
      if (sticky == ST_OK) sticky = s;
    endfunction

    function logic [15:0] clip(int unsigned v);
      return (v > POS_MAX) ? POS_MAX : v[15:0];
    endfunction

    function void note_input(logic k, logic [7:0] c);
      token_t    t;
      tok_kind_t tk;
      bit        cmd;
      cmd = 1'b1;
      tk  = TK_PLUS;
      if (k == ITEM_END) begin
        if (depth != 0) raise(ST_UNMATCHED_OPEN);
        t.kind   = TK_END;
        t.pos    = clip(n_tokens);
        t.jump   = '0;
        t.status = sticky;
        want_q.push_back(t);
        restart();
        return;
      end
      case (c)
        CH_PLUS:  tk = TK_PLUS;
        CH_MINUS: tk = TK_MINUS;
        CH_COMMA: tk = TK_COMMA;
        CH_DOT:   tk = TK_DOT;
        CH_LT:    tk = TK_LT;
        CH_GT:    tk = TK_GT;
        CH_OPEN:  tk = TK_OPEN;
        CH_CLOSE: tk = TK_CLOSE;
        default:  cmd = 1'b0;
      endcase
      if (!cmd) return;
      t.kind = tk;
      t.pos  = clip(n_tokens);
      t.jump = '0;
      // once the program is too long nothing is pushed, popped or counted
      if (n_tokens >= MAX_TOK) begin
        raise(ST_TOO_LONG);
      end else begin
        if (tk == TK_OPEN) begin
          if (depth >= MAX_NEST) begin
            raise(ST_TOO_DEEP);
          end else begin
            open_pos[depth] = t.pos;
            depth++;
          end
        end else if (tk == TK_CLOSE) begin
          if (depth == 0) begin
            raise(ST_UNMATCHED_CLOSE);
          end else begin
            depth--;
            t.jump = open_pos[depth];
          end
        end
        n_tokens++;
      end
      t.status = sticky;
      want_q.push_back(t);
    endfunction

    function bit same(string what, logic [15:0] want, logic [15:0] got);
      if (got === want) return 1'b1;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      return 1'b0;
    endfunction

    function void check_result(token_t got);
      token_t want;
      bit     ok;
      if (want_q.size() == 0) begin
        $display("%0t: token_code mismatch, expected none, actual %0d (position %0d)",
                 $time, got.kind, got.pos);
        errors++;
        return;
      end
      want = want_q.pop_front();
      ok = same("token_code", 16'(want.kind), 16'(got.kind)) &
           same("position", want.pos, got.pos) &
           same("jump_position", want.jump, got.jump) &
           same("status", 16'(want.status), 16'(got.status));
      if (!ok) errors++;
    endfunction

    function int pending();
      return want_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bmt_in_if  prog_bus ();
  bmt_out_if tok_bus ();

  bracket_matching_tokenizer_unit #(
    .MAX_TOKENS  (MAX_TOK),
    .MAX_NESTING (MAX_NEST)
  ) DUT (
    .clk  (clk),
    .rst  (rst),
    .prog (prog_bus),
    .tok  (tok_bus)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  token_scoreboard sb;
  int              burst_left;
  int unsigned     items_sent;
  int unsigned     cycle_count;
  rx_mode_t        rx_mode;

  // receiver: takes tokens and stalls on a randomly chosen pattern that changes periodically
  always @(posedge clk) begin
    token_t got;
    if (rst) begin
      tok_bus.ready <= 1'b0;
      cycle_count   = 0;
      rx_mode       = RX_OPEN;
    end else begin
      if (tok_bus.valid && tok_bus.ready) begin
        got.kind   = tok_bus.token_code;
        got.pos    = tok_bus.position;
        got.jump   = tok_bus.jump_position;
        got.status = tok_bus.status;
        sb.check_result(got);
      end
      cycle_count++;
      if (cycle_count % 200 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   tok_bus.ready <= 1'b1;
        RX_COIN:   tok_bus.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: tok_bus.ready <= (cycle_count[1:0] == 2'b11);
        default:   tok_bus.ready <= ($urandom_range(0, 6) != 0);
      endcase
    end
  end

  function automatic bit is_command(logic [7:0] c);
    case (c)
      CH_PLUS, CH_MINUS, CH_COMMA, CH_DOT, CH_LT, CH_GT, CH_OPEN, CH_CLOSE: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] char_of(tok_kind_t k);
    logic [7:0] c;
    case (k)
      TK_PLUS:  c = CH_PLUS;
      TK_MINUS: c = CH_MINUS;
      TK_COMMA: c = CH_COMMA;
      TK_DOT:   c = CH_DOT;
      TK_LT:    c = CH_LT;
      TK_GT:    c = CH_GT;
      TK_OPEN:  c = CH_OPEN;
      default:  c = CH_CLOSE;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_command(c));
    return c;
  endfunction

  // sender: bursts of random length, random gaps between them
  task automatic push_byte(input logic k, input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        prog_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    prog_bus.valid     <= 1'b1;
    prog_bus.kind      <= k;
    prog_bus.char_code <= c;
    do @(posedge clk); while (!prog_bus.ready);
    sb.note_input(k, c);
    items_sent++;
  endtask

  task automatic push_cmd(input tok_kind_t k);
    push_byte(ITEM_BYTE, char_of(k));
  endtask

  task automatic end_program();
    push_byte(ITEM_END, 8'($urandom_range(0, 255)));
  endtask

  // hold the sender off until every outstanding token has come back
  task automatic wait_for_tokens();
    prog_bus.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic nest_program(input int opens);
    for (int i = 0; i < opens; i++) push_cmd(TK_OPEN);
    push_cmd(TK_PLUS);
    for (int i = 0; i < opens; i++) push_cmd(TK_CLOSE);
    end_program();
  endtask

  // style 7 leaves opens behind, 8 lets stray closes through, 9 is raw bytes
  task automatic random_program();
    int style;
    int len;
    int depth;
    int r;
    style = $urandom_range(0, 9);
    len   = $urandom_range(1, 40);
    depth = 0;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (style == 9) begin
        push_byte((r < 4) ? ITEM_END : ITEM_BYTE, 8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        push_byte(ITEM_BYTE, noise_byte());
      end else if (r < 32 && depth < 12) begin
        push_cmd(TK_OPEN);
        depth++;
      end else if (r < 52 && (depth > 0 || style == 8)) begin
        push_cmd(TK_CLOSE);
        if (depth > 0) depth--;
      end else begin
        push_cmd(tok_kind_t'($urandom_range(0, 5)));
      end
    end
    if (style != 7 && style != 9) begin
      while (depth > 0) begin
        push_cmd(TK_CLOSE);
        depth--;
      end
    end
    end_program();
  endtask

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    sb         = new();
    burst_left = 0;
    items_sent = 0;
    rst                <= 1'b1;
    prog_bus.valid     <= 1'b0;
    prog_bus.kind      <= ITEM_BYTE;
    prog_bus.char_code <= 8'd0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every command, ignored bytes at both extremes, nested pairs
    for (int k = 0; k < 6; k++) push_cmd(tok_kind_t'(k));
    push_byte(ITEM_BYTE, 8'h00);
    push_byte(ITEM_BYTE, 8'hFF);
    push_cmd(TK_OPEN);
    push_cmd(TK_OPEN);
    push_cmd(TK_CLOSE);
    push_cmd(TK_CLOSE);
    push_byte(ITEM_END, 8'hFF);
    // stray close first, so it must win over the unmatched open
    push_cmd(TK_CLOSE);
    push_cmd(TK_OPEN);
    push_byte(ITEM_END, 8'h00);
    push_cmd(TK_OPEN);
    push_byte(ITEM_END, 8'h5A);
    push_byte(ITEM_END, 8'hA5);
    wait_for_tokens();

    nest_program(MAX_NEST);
    nest_program(MAX_NEST + 1);
    wait_for_tokens();

    while (items_sent < TOTAL_ITEMS) begin
      random_program();
      if ($urandom_range(0, 9) == 0) wait_for_tokens();
    end

    wait_for_tokens();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
